@@ hdl/src_pkg.sv @@
// ----------------------------------------------------------------------------
// src_pkg: shared types and constants of the sprite rectangle clipper
// Holds the configuration register map, the lane order of the four texture
// coordinate interpolators and the edge cut flags passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package src_pkg;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register index, taken from the word address of the configuration port.
	typedef enum logic [1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_TOP    = 2'd1,
		REG_CLIP_RIGHT  = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} src_reg_t;

	// One lane for each texture coordinate that an edge cut can move.
	localparam int NUM_LANES    = 4;
	localparam int LANE_S_START = 0;
	localparam int LANE_S_END   = 1;
	localparam int LANE_T_START = 2;
	localparam int LANE_T_END   = 3;

	// Classification of one quad against the clip rectangle.
	typedef struct packed {
		logic culled;
		logic left;
		logic right;
		logic top;
		logic bottom;
	} src_cut_t;

endpackage

`default_nettype wire

@@ hdl/src_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// src_cfg_regs: clip rectangle registers
// APB-style register file holding the four clip rectangle edges.
// ----------------------------------------------------------------------------
`default_nettype none

module src_cfg_regs import src_pkg::*; #(
	parameter int CW = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic signed [CW-1:0]         clip_left,
	output logic signed [CW-1:0]         clip_top,
	output logic signed [CW-1:0]         clip_right,
	output logic signed [CW-1:0]         clip_bottom
);

	logic     wr_en;
	src_reg_t reg_idx;

	// A write transfer completes in the access cycle.
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = src_reg_t'(paddr[APB_ADDR_W-1:2]);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left   <= '0;
			clip_top    <= '0;
			clip_right  <= '0;
			clip_bottom <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CLIP_LEFT:   clip_left   <= pwdata[CW-1:0];
				REG_CLIP_TOP:    clip_top    <= pwdata[CW-1:0];
				REG_CLIP_RIGHT:  clip_right  <= pwdata[CW-1:0];
				REG_CLIP_BOTTOM: clip_bottom <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// Read data is the sign-extended register value.
	always_comb begin
		case (reg_idx)
			REG_CLIP_LEFT:   prdata = APB_DATA_W'(clip_left);
			REG_CLIP_TOP:    prdata = APB_DATA_W'(clip_top);
			REG_CLIP_RIGHT:  prdata = APB_DATA_W'(clip_right);
			REG_CLIP_BOTTOM: prdata = APB_DATA_W'(clip_bottom);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/src_setup.sv @@
// ----------------------------------------------------------------------------
// src_setup: edge classification and clipped geometry
// Two pipeline stages: the first forms the right and bottom edges, the
// second tests the quad against the clip rectangle, computes the clipped
// position and size and prepares the divider and interpolator operands.
// ----------------------------------------------------------------------------
`default_nettype none

module src_setup import src_pkg::*; #(
	parameter int CW = 24,
	parameter int TW = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [CW-1:0]                 pos_x,
	input  logic signed [CW-1:0]                 pos_y,
	input  logic signed [CW-1:0]                 size_w,
	input  logic signed [CW-1:0]                 size_h,
	input  logic signed [TW-1:0]                 tex_s_start,
	input  logic signed [TW-1:0]                 tex_t_start,
	input  logic signed [TW-1:0]                 tex_s_end,
	input  logic signed [TW-1:0]                 tex_t_end,
	input  logic signed [CW-1:0]                 clip_left,
	input  logic signed [CW-1:0]                 clip_top,
	input  logic signed [CW-1:0]                 clip_right,
	input  logic signed [CW-1:0]                 clip_bottom,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output src_cut_t                             cut,
	output logic signed [CW-1:0]                 geo_x,
	output logic signed [CW-1:0]                 geo_y,
	output logic signed [CW-1:0]                 geo_w,
	output logic signed [CW-1:0]                 geo_h,
	output logic [NUM_LANES-1:0][CW-1:0]         dividend,
	output logic [NUM_LANES-1:0][CW-1:0]         divisor,
	output logic [NUM_LANES-1:0][TW-1:0]         from,
	output logic [NUM_LANES-1:0][TW:0]           diff
);

	localparam int XW = CW + 2;
	localparam logic signed [XW-1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
	localparam logic signed [XW-1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};

	logic en_s1, en_s2;
	logic vld_s1, vld_s2;

	logic signed [CW-1:0] x_s1, y_s1, w_s1, h_s1;
	logic signed [CW:0]   right_s1, bottom_s1;
	logic signed [TW-1:0] ss_s1, ts_s1, se_s1, te_s1;

	logic signed [XW-1:0] cl, ct, cr, cb;
	logic signed [XW-1:0] lx, ty, rx, by, wx, hx;
	logic signed [XW-1:0] new_x, new_y, new_w, new_h;
	logic signed [XW-1:0] lost_l, lost_r, lost_t, lost_b;
	logic                 empty, outside, active;
	src_cut_t             cut_c;
	logic [CW-1:0]        sat_w, sat_h;

	src_cut_t                     cut_s2;
	logic signed [CW-1:0]         x_s2, y_s2, w_s2, h_s2;
	logic [NUM_LANES-1:0][CW-1:0] dvd_s2, dvs_s2;
	logic [NUM_LANES-1:0][TW-1:0] from_s2;
	logic [NUM_LANES-1:0][TW:0]   diff_s2;

	// Stall chain: a stage takes new data when it is empty or drains.
	assign en_s2    = ~vld_s2 | out_ready;
	assign en_s1    = ~vld_s1 | en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: exact right and bottom edges, one bit wider than a coordinate.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1      <= pos_x;
			y_s1      <= pos_y;
			w_s1      <= size_w;
			h_s1      <= size_h;
			right_s1  <= (CW+1)'(pos_x) + (CW+1)'(size_w);
			bottom_s1 <= (CW+1)'(pos_y) + (CW+1)'(size_h);
			ss_s1     <= tex_s_start;
			ts_s1     <= tex_t_start;
			se_s1     <= tex_s_end;
			te_s1     <= tex_t_end;
		end
	end

	// Stage 2: classify the quad and find the crossed edges.
	always_comb begin
		cl = XW'(clip_left);
		ct = XW'(clip_top);
		cr = XW'(clip_right);
		cb = XW'(clip_bottom);
		lx = XW'(x_s1);
		ty = XW'(y_s1);
		rx = XW'(right_s1);
		by = XW'(bottom_s1);
		wx = XW'(w_s1);
		hx = XW'(h_s1);

		empty   = (cr <= cl) || (cb <= ct);
		outside = (rx <= cl) || (lx >= cr) || (by <= ct) || (ty >= cb);
		active  = !empty && !outside;

		cut_c.culled = !empty && outside;
		cut_c.left   = active && (lx < cl);
		cut_c.right  = active && (rx > cr);
		cut_c.top    = active && (ty < ct);
		cut_c.bottom = active && (by > cb);
	end

	// Clipped position and size; the far cuts use the adjusted near edge.
	always_comb begin
		new_x = cut_c.left ? cl : lx;
		new_y = cut_c.top  ? ct : ty;
		if (cut_c.right)     new_w = cr - new_x;
		else if (cut_c.left) new_w = rx - cl;
		else                 new_w = wx;
		if (cut_c.bottom)    new_h = cb - new_y;
		else if (cut_c.top)  new_h = by - ct;
		else                 new_h = hx;

		if (new_w > SAT_HI)      sat_w = SAT_HI[CW-1:0];
		else if (new_w < SAT_LO) sat_w = SAT_LO[CW-1:0];
		else                     sat_w = new_w[CW-1:0];
		if (new_h > SAT_HI)      sat_h = SAT_HI[CW-1:0];
		else if (new_h < SAT_LO) sat_h = SAT_LO[CW-1:0];
		else                     sat_h = new_h[CW-1:0];
	end

	// Extent lost at each cut edge; always below the full extent.
	assign lost_l = cl - lx;
	assign lost_r = rx - cr;
	assign lost_t = ct - ty;
	assign lost_b = by - cb;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cut_s2 <= cut_c;
			x_s2   <= new_x[CW-1:0];
			y_s2   <= new_y[CW-1:0];
			w_s2   <= sat_w;
			h_s2   <= sat_h;

			dvd_s2[LANE_S_START] <= cut_c.left   ? lost_l[CW-1:0] : '0;
			dvd_s2[LANE_S_END]   <= cut_c.right  ? lost_r[CW-1:0] : '0;
			dvd_s2[LANE_T_START] <= cut_c.top    ? lost_t[CW-1:0] : '0;
			dvd_s2[LANE_T_END]   <= cut_c.bottom ? lost_b[CW-1:0] : '0;
			dvs_s2[LANE_S_START] <= cut_c.left   ? w_s1 : '0;
			dvs_s2[LANE_S_END]   <= cut_c.right  ? w_s1 : '0;
			dvs_s2[LANE_T_START] <= cut_c.top    ? h_s1 : '0;
			dvs_s2[LANE_T_END]   <= cut_c.bottom ? h_s1 : '0;

			from_s2[LANE_S_START] <= ss_s1;
			from_s2[LANE_S_END]   <= se_s1;
			from_s2[LANE_T_START] <= ts_s1;
			from_s2[LANE_T_END]   <= te_s1;
			diff_s2[LANE_S_START] <= (TW+1)'(se_s1) - (TW+1)'(ss_s1);
			diff_s2[LANE_S_END]   <= (TW+1)'(ss_s1) - (TW+1)'(se_s1);
			diff_s2[LANE_T_START] <= (TW+1)'(te_s1) - (TW+1)'(ts_s1);
			diff_s2[LANE_T_END]   <= (TW+1)'(ts_s1) - (TW+1)'(te_s1);
		end
	end

	assign out_valid = vld_s2;
	assign cut       = cut_s2;
	assign geo_x     = x_s2;
	assign geo_y     = y_s2;
	assign geo_w     = w_s2;
	assign geo_h     = h_s2;
	assign dividend  = dvd_s2;
	assign divisor   = dvs_s2;
	assign from      = from_s2;
	assign diff      = diff_s2;

endmodule

`default_nettype wire

@@ hdl/src_divider.sv @@
// ----------------------------------------------------------------------------
// src_divider: pipelined fraction divider
// Restoring division with one quotient bit per stage, for several lanes at
// once. The dividend is below the divisor, so the quotient is a pure
// fraction of QW bits. A sideband word travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module src_divider #(
	parameter int LANES = 4,
	parameter int DW    = 24,
	parameter int QW    = 16,
	parameter int SW    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LANES-1:0][DW-1:0]     dividend,
	input  logic [LANES-1:0][DW-1:0]     divisor,
	input  logic [SW-1:0]                side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LANES-1:0][QW-1:0]     quotient,
	output logic [SW-1:0]                side_out
);

	logic                     vld_s  [QW];
	logic                     en     [QW+1];
	logic [LANES-1:0][DW-1:0] rem_s  [QW];
	logic [LANES-1:0][DW-1:0] dvs_s  [QW];
	logic [LANES-1:0][QW-1:0] quo_s  [QW];
	logic [SW-1:0]            side_s [QW];

	assign en[QW] = out_ready;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                     vld_in;
		logic [LANES-1:0][DW-1:0] rem_in, dvs_in, rem_nx;
		logic [LANES-1:0][QW-1:0] quo_in, quo_nx;
		logic [SW-1:0]            side_in;

		// Operands come from the ports or from the previous stage.
		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = dividend;
			assign dvs_in  = divisor;
			assign quo_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign dvs_in  = dvs_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		// A stage takes new data when it is empty or its item moves on.
		assign en[k] = ~vld_s[k] | en[k+1];

		// One restoring step per lane: shift, trial subtract, keep or restore.
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [DW:0] shifted;
				logic [DW:0] trial;
				logic        ge;
				shifted   = {rem_in[l], 1'b0};
				trial     = shifted - {1'b0, dvs_in[l]};
				ge        = shifted >= {1'b0, dvs_in[l]};
				rem_nx[l] = ge ? trial[DW-1:0] : shifted[DW-1:0];
				quo_nx[l] = {quo_in[l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= rem_nx;
				dvs_s[k]  <= dvs_in;
				quo_s[k]  <= quo_nx;
				side_s[k] <= side_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[QW-1];
	assign quotient  = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

`default_nettype wire

@@ hdl/src_lerp.sv @@
// ----------------------------------------------------------------------------
// src_lerp: texture coordinate interpolator
// Two pipeline stages: the first multiplies each fraction by the coordinate
// difference, the second floors the product and adds it to the lane's own
// coordinate. Lanes without a cut keep their coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module src_lerp #(
	parameter int LANES = 4,
	parameter int TW    = 20,
	parameter int FB    = 16,
	parameter int SW    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LANES-1:0][FB-1:0]     frac,
	input  logic [LANES-1:0][TW-1:0]     from,
	input  logic [LANES-1:0][TW:0]       diff,
	input  logic [LANES-1:0]             apply,
	input  logic [SW-1:0]                side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LANES-1:0][TW-1:0]     result,
	output logic [SW-1:0]                side_out
);

	localparam int PW = FB + TW + 2;

	logic en_s1, en_s2;
	logic vld_s1, vld_s2;

	logic signed [PW-1:0]     prod_s1 [LANES];
	logic [LANES-1:0][TW-1:0] from_s1;
	logic [LANES-1:0]         apply_s1;
	logic [SW-1:0]            side_s1;

	logic [LANES-1:0][TW-1:0] res_c;
	logic [LANES-1:0][TW-1:0] res_s2;
	logic [SW-1:0]            side_s2;

	// Stall chain.
	assign en_s2    = ~vld_s2 | out_ready;
	assign en_s1    = ~vld_s1 | en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: fraction times signed coordinate difference.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= $signed({1'b0, frac[l]}) * $signed(diff[l]);
			end
			from_s1  <= from;
			apply_s1 <= apply;
			side_s1  <= side;
		end
	end

	// Stage 2: the arithmetic shift floors toward minus infinity.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic signed [PW-1:0] step;
			step     = prod_s1[l] >>> FB;
			res_c[l] = apply_s1[l] ? (from_s1[l] + step[TW-1:0]) : from_s1[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2  <= res_c;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign result    = res_s2;
	assign side_out  = side_s2;

endmodule

`default_nettype wire

@@ hdl/sprite_rect_clipper.sv @@
// ----------------------------------------------------------------------------
// sprite_rect_clipper: scissor clip of screen-space quads
// Clips each quad against the configured clip rectangle and interpolates
// the texture coordinates of every cut edge.
// ----------------------------------------------------------------------------
// Usage:
//   Quads enter on the in_valid/in_ready channel, one transfer per quad, and
//   leave on the out_valid/out_ready channel with exactly one result each,
//   in order. The clip rectangle is written through the APB-style port while
//   no quad is in flight; an empty rectangle passes quads through unchanged.
//   The pipeline has two setup stages, one divider stage per fraction bit, a
//   multiply stage and an output stage. Throughput is one quad per cycle
//   while the receiver accepts results; the bit-per-stage divider pipeline
//   sets the depth but not the rate.
//   Every stage has its own valid bit and takes a new quad whenever it is
//   empty or its quad moves on, so bubbles are squeezed out while the
//   receiver stalls and input is refused only when all stages hold quads.
//   Reset clears the valid bits and the clip rectangle to zero, which
//   disables clipping until the rectangle is written.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rect_clipper import src_pkg::*; #(
	parameter int COORD_WIDTH   = 24,
	parameter int TEX_WIDTH     = 20,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [APB_ADDR_W-1:0]           paddr,
	input  logic [APB_DATA_W-1:0]           pwdata,
	output logic [APB_DATA_W-1:0]           prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   pos_x,
	input  logic signed [COORD_WIDTH-1:0]   pos_y,
	input  logic signed [COORD_WIDTH-1:0]   size_w,
	input  logic signed [COORD_WIDTH-1:0]   size_h,
	input  logic signed [TEX_WIDTH-1:0]     tex_s_start,
	input  logic signed [TEX_WIDTH-1:0]     tex_t_start,
	input  logic signed [TEX_WIDTH-1:0]     tex_s_end,
	input  logic signed [TEX_WIDTH-1:0]     tex_t_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            culled,
	output logic signed [COORD_WIDTH-1:0]   clipped_x,
	output logic signed [COORD_WIDTH-1:0]   clipped_y,
	output logic signed [COORD_WIDTH-1:0]   clipped_w,
	output logic signed [COORD_WIDTH-1:0]   clipped_h,
	output logic signed [TEX_WIDTH-1:0]     clipped_s_start,
	output logic signed [TEX_WIDTH-1:0]     clipped_t_start,
	output logic signed [TEX_WIDTH-1:0]     clipped_s_end,
	output logic signed [TEX_WIDTH-1:0]     clipped_t_end
);

	localparam int CW     = COORD_WIDTH;
	localparam int TW     = TEX_WIDTH;
	localparam int FB     = FRACTION_BITS;
	localparam int DIV_SW = $bits(src_cut_t) + 4*CW + NUM_LANES*(2*TW + 1);
	localparam int LRP_SW = 1 + 4*CW;

	logic signed [CW-1:0] clip_left, clip_top, clip_right, clip_bottom;

	logic                            set_valid, set_ready;
	src_cut_t                        set_cut;
	logic signed [CW-1:0]            set_x, set_y, set_w, set_h;
	logic [NUM_LANES-1:0][CW-1:0]    set_dividend, set_divisor;
	logic [NUM_LANES-1:0][TW-1:0]    set_from;
	logic [NUM_LANES-1:0][TW:0]      set_diff;
	logic [DIV_SW-1:0]               set_side;

	logic                            div_valid, div_ready;
	logic [NUM_LANES-1:0][FB-1:0]    div_quo;
	logic [DIV_SW-1:0]               div_side;
	src_cut_t                        div_cut;
	logic [CW-1:0]                   div_x, div_y, div_w, div_h;
	logic [NUM_LANES-1:0][TW-1:0]    div_from;
	logic [NUM_LANES-1:0][TW:0]      div_diff;
	logic [NUM_LANES-1:0]            div_apply;
	logic [LRP_SW-1:0]               lrp_side_in;

	logic [NUM_LANES-1:0][TW-1:0]    lrp_res;
	logic [LRP_SW-1:0]               lrp_side;

	// Configuration registers; every transfer completes without wait states.
	assign pready = 1'b1;

	src_cfg_regs #(
		.CW (CW)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.clip_left   (clip_left),
		.clip_top    (clip_top),
		.clip_right  (clip_right),
		.clip_bottom (clip_bottom)
	);

	// Classification and clipped geometry.
	src_setup #(
		.CW (CW),
		.TW (TW)
	) u_setup (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.size_w      (size_w),
		.size_h      (size_h),
		.tex_s_start (tex_s_start),
		.tex_t_start (tex_t_start),
		.tex_s_end   (tex_s_end),
		.tex_t_end   (tex_t_end),
		.clip_left   (clip_left),
		.clip_top    (clip_top),
		.clip_right  (clip_right),
		.clip_bottom (clip_bottom),
		.out_valid   (set_valid),
		.out_ready   (set_ready),
		.cut         (set_cut),
		.geo_x       (set_x),
		.geo_y       (set_y),
		.geo_w       (set_w),
		.geo_h       (set_h),
		.dividend    (set_dividend),
		.divisor     (set_divisor),
		.from        (set_from),
		.diff        (set_diff)
	);

	// Everything that does not enter the division rides along as sideband.
	assign set_side = {set_cut, set_x, set_y, set_w, set_h, set_from, set_diff};

	src_divider #(
		.LANES (NUM_LANES),
		.DW    (CW),
		.QW    (FB),
		.SW    (DIV_SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (set_valid),
		.in_ready  (set_ready),
		.dividend  (set_dividend),
		.divisor   (set_divisor),
		.side      (set_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quotient  (div_quo),
		.side_out  (div_side)
	);

	assign {div_cut, div_x, div_y, div_w, div_h, div_from, div_diff} = div_side;

	// Each lane is adjusted only when its edge was cut.
	always_comb begin
		div_apply               = '0;
		div_apply[LANE_S_START] = div_cut.left;
		div_apply[LANE_S_END]   = div_cut.right;
		div_apply[LANE_T_START] = div_cut.top;
		div_apply[LANE_T_END]   = div_cut.bottom;
	end

	assign lrp_side_in = {div_cut.culled, div_x, div_y, div_w, div_h};

	src_lerp #(
		.LANES (NUM_LANES),
		.TW    (TW),
		.FB    (FB),
		.SW    (LRP_SW)
	) u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.frac      (div_quo),
		.from      (div_from),
		.diff      (div_diff),
		.apply     (div_apply),
		.side      (lrp_side_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (lrp_res),
		.side_out  (lrp_side)
	);

	// Result fields.
	assign {culled, clipped_x, clipped_y, clipped_w, clipped_h} = lrp_side;
	assign clipped_s_start = lrp_res[LANE_S_START];
	assign clipped_s_end   = lrp_res[LANE_S_END];
	assign clipped_t_start = lrp_res[LANE_T_START];
	assign clipped_t_end   = lrp_res[LANE_T_END];

endmodule

`default_nettype wire
